// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

    // The ring buffer wraps by truncation, so DEPTH must be a power of two.
    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ_AT    = 3'd4,
        KIND_INSERT_AT  = 3'd5,
        KIND_CLEAR      = 3'd6
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_SHIFT = 2'd2
    } t_state;

    typedef struct packed {
        logic accept;
        logic finish;
        logic shift_start;
        logic shift_step;
    } t_dp_cmd;

    typedef struct packed {
        logic need_shift;
        logic shift_last;
        logic out_free;
    } t_dp_stat;

    // Physical slot of a logical position counted from the head.
    function automatic t_ptr slot_of(input t_ptr head, input t_cnt logical);
        return head + logical[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_if.sv =====
`default_nettype none

interface bdq_in_if
    import bdq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   value;
    logic [POS_W-1:0]    position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface bdq_out_if
    import bdq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_value;
    logic [STAT_W-1:0]   status;
    logic [CNT_W-1:0]    count_after;

    modport source (output valid, output read_value, output status, output count_after,
                     input ready);
    modport sink   (input valid, input read_value, input status, input count_after,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_ctrl.sv =====
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.need_shift) begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_dp.sv =====
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [DATA_W-1:0]   i_value,
    input  wire logic [POS_W-1:0]    i_position,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [DATA_W-1:0]        o_read_value,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_count_after
);

    // Control state.
    t_ptr r_head;
    t_cnt r_count;
    logic r_shifted;
    logic r_out_valid;

    // Latched operation and shift index.
    logic [KIND_W-1:0] r_kind;
    t_data             r_value;
    logic [POS_W-1:0]  r_pos;
    t_cnt              r_idx;

    // Result register.
    t_data   r_out_rv;
    t_status r_out_st;
    t_cnt    r_out_cnt;

    // Memory ports.
    logic  ram_we;
    t_ptr  ram_waddr;
    t_data ram_wdata;
    logic  ram_re;
    t_ptr  ram_raddr;
    t_data ram_rdata;

    // Outcome of the latched operation.
    t_ptr    n_head;
    t_cnt    n_count;
    logic    fin_we;
    t_ptr    fin_waddr;
    t_status fin_st;
    t_data   fin_rv;
    logic    insert_ok;
    t_ptr    acc_raddr;

    logic is_full;
    logic is_empty;
    t_cnt pos_ext;
    t_cnt in_pos_ext;
    logic pos_in_range;

    assign is_full      = (r_count == t_cnt'(DEPTH));
    assign is_empty     = (r_count == '0);
    assign pos_ext      = t_cnt'(r_pos);
    assign in_pos_ext   = t_cnt'(i_position);
    assign pos_in_range = (pos_ext < r_count);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        fin_we    = 1'b0;
        fin_waddr = slot_of(r_head, pos_ext);
        fin_st    = ST_OK;
        fin_rv    = '0;
        insert_ok = 1'b0;
        case (r_kind)
            KIND_PUSH_FRONT: begin
                if (is_full) begin
                    fin_st = ST_FULL;
                end else begin
                    n_head    = r_head - t_ptr'(1);
                    n_count   = r_count + t_cnt'(1);
                    fin_we    = 1'b1;
                    fin_waddr = r_head - t_ptr'(1);
                end
            end
            KIND_PUSH_BACK: begin
                if (is_full) begin
                    fin_st = ST_FULL;
                end else begin
                    n_count   = r_count + t_cnt'(1);
                    fin_we    = 1'b1;
                    fin_waddr = slot_of(r_head, r_count);
                end
            end
            KIND_POP_FRONT: begin
                if (is_empty) begin
                    fin_st = ST_EMPTY;
                end else begin
                    fin_rv  = ram_rdata;
                    n_head  = r_head + t_ptr'(1);
                    n_count = r_count - t_cnt'(1);
                end
            end
            KIND_POP_BACK: begin
                if (is_empty) begin
                    fin_st = ST_EMPTY;
                end else begin
                    fin_rv  = ram_rdata;
                    n_count = r_count - t_cnt'(1);
                end
            end
            KIND_READ_AT: begin
                if (is_empty) begin
                    fin_st = ST_EMPTY;
                end else if (!pos_in_range) begin
                    fin_st = ST_RANGE;
                end else begin
                    fin_rv = ram_rdata;
                end
            end
            KIND_INSERT_AT: begin
                if (r_pos == '0) begin
                    // Insert at the front is a plain push front.
                    if (is_full) begin
                        fin_st = ST_FULL;
                    end else begin
                        n_head    = r_head - t_ptr'(1);
                        n_count   = r_count + t_cnt'(1);
                        fin_we    = 1'b1;
                        fin_waddr = r_head - t_ptr'(1);
                    end
                end else if (!pos_in_range) begin
                    fin_st = ST_RANGE;
                end else if (is_full) begin
                    fin_st = ST_FULL;
                end else begin
                    insert_ok = 1'b1;
                    n_count   = r_count + t_cnt'(1);
                    fin_we    = 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    // Read address for the item being accepted, from the live port fields.
    always_comb begin
        case (i_kind)
            KIND_POP_FRONT: acc_raddr = r_head;
            KIND_READ_AT:   acc_raddr = slot_of(r_head, in_pos_ext);
            KIND_POP_BACK,
            KIND_INSERT_AT: acc_raddr = slot_of(r_head, r_count - t_cnt'(1));
            default:        acc_raddr = r_head;
        endcase
    end

    assign o_stat.need_shift = insert_ok && !r_shifted;
    assign o_stat.shift_last = (r_idx == pos_ext + t_cnt'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // During the shift, the word most recently read moves up one slot while the
    // next lower one is fetched.
    assign ram_we    = (i_cmd.finish && fin_we) || i_cmd.shift_step;
    assign ram_waddr = i_cmd.shift_step ? slot_of(r_head, r_idx) : fin_waddr;
    assign ram_wdata = i_cmd.shift_step ? ram_rdata : r_value;
    assign ram_re    = i_cmd.accept || (i_cmd.shift_step && !o_stat.shift_last);
    assign ram_raddr = i_cmd.accept ? acc_raddr
                                    : slot_of(r_head, r_idx - t_cnt'(2));

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_shifted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.accept) begin
                r_shifted <= 1'b0;
            end else if (i_cmd.shift_step && o_stat.shift_last) begin
                r_shifted <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.shift_start) begin
            r_idx <= r_count;
        end else if (i_cmd.shift_step) begin
            r_idx <= r_idx - t_cnt'(1);
        end
        if (i_cmd.finish) begin
            r_out_rv  <= fin_rv;
            r_out_st  <= fin_st;
            r_out_cnt <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_rv;
    assign o_status      = r_out_st;
    assign o_count_after = r_out_cnt;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_indexed_insert.sv =====
`default_nettype none

// Channel   Dir  Beat fields                          Handshake
// i_in      in   kind, value, position                valid / ready
// o_out     out  read_value, status, count_after      valid / ready
//
// Push, pop, read, clear and rejected operations are accepted while the entry memory
// is read, then finish by updating pointers and loading the result; a new item is
// taken only once the last has finished. A valid insert away from the front runs a
// shift loop before it finishes, moving one entry per cycle through the single write port.
// Reset (synchronous, active low) empties the queue; the entry memory is not cleared.
// A stalled output holds its result; the next item is accepted but waits to finish until it is taken.

module bounded_deque_with_indexed_insert
    import bdq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bdq_in_if.sink       i_in,
    bdq_out_if.source    o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bdq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_in.kind),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_read_value  (o_out.read_value),
        .o_status      (o_out.status),
        .o_count_after (o_out.count_after)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // Only one controller command may be issued in a cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    // After an item is taken, no other item enters until it has finished.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !i_in.ready)
        else $error("item accepted while previous item still in progress");

    // A rejected operation never returns data.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_OK)) |-> (o_out.read_value == '0))
        else $error("nonzero read value with error status");

    // A full status means the queue really holds DEPTH entries.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_FULL)) |->
            (o_out.count_after == t_cnt'(DEPTH)))
        else $error("full status with count below the bound");
`endif

endmodule

`default_nettype wire

// ===== test/bounded_deque_with_indexed_insert_tb.sv =====
`timescale 1ns / 100ps

module bounded_deque_with_indexed_insert_tb;
    import bdq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        logic [KIND_W-1:0] kind;
        t_data             value;
        logic [POS_W-1:0]  position;
    } t_op_beat;

    typedef struct {
        t_data   read_value;
        t_status status;
        t_cnt    count_after;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    bdq_in_if  in_if ();
    bdq_out_if out_if ();

    bounded_deque_with_indexed_insert DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_op_beat      op_queue[$];
    t_deque_result deque_results_due[$];

    // Predicted deque contents.
    t_data deque_store [DEPTH];
    t_ptr  deque_head = '0;
    t_cnt  deque_fill = '0;

    // Fill level as the generator sees it, used to aim positions and to know when the queue is full.
    int est_fill = 0;

    int  mismatches   = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_go   = 1'b0;
    logic rx_hold     = 1'b0;

    function automatic t_ptr deque_slot(input int idx);
        return deque_head + t_ptr'(idx);
    endfunction

    function automatic t_status deque_push_front(input t_data value);
        if (deque_fill == DEPTH) begin
            return ST_FULL;
        end
        deque_head = deque_head - t_ptr'(1);
        deque_store[deque_head] = value;
        deque_fill++;
        return ST_OK;
    endfunction

    function automatic t_deque_result deque_apply(input logic [KIND_W-1:0] kind,
                                                  input t_data value,
                                                  input logic [POS_W-1:0] pos);
        t_deque_result res;
        int i;
        res.read_value = '0;
        res.status     = ST_OK;
        case (kind)
            KIND_PUSH_FRONT: begin
                res.status = deque_push_front(value);
            end
            KIND_PUSH_BACK: begin
                if (deque_fill == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    deque_store[deque_slot(int'(deque_fill))] = value;
                    deque_fill++;
                end
            end
            KIND_POP_FRONT: begin
                if (deque_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = deque_store[deque_head];
                    deque_head = deque_head + t_ptr'(1);
                    deque_fill--;
                end
            end
            KIND_POP_BACK: begin
                if (deque_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = deque_store[deque_slot(int'(deque_fill) - 1)];
                    deque_fill--;
                end
            end
            KIND_READ_AT: begin
                if (deque_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= deque_fill) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = deque_store[deque_slot(int'(pos))];
                end
            end
            KIND_INSERT_AT: begin
                // The range check comes before the fullness check.
                if (pos == 0) begin
                    res.status = deque_push_front(value);
                end else if (pos >= deque_fill) begin
                    res.status = ST_RANGE;
                end else if (deque_fill == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = int'(deque_fill); i > int'(pos); i--) begin
                        deque_store[deque_slot(i)] = deque_store[deque_slot(i - 1)];
                    end
                    deque_store[deque_slot(int'(pos))] = value;
                    deque_fill++;
                end
            end
            KIND_CLEAR: begin
                deque_fill = '0;
                deque_head = '0;
            end
            default: ;
        endcase
        res.count_after = deque_fill;
        return res;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] kind, input t_data value,
                            input logic [POS_W-1:0] pos);
        t_op_beat b;
        b.kind     = kind;
        b.value    = value;
        b.position = pos;
        op_queue.push_back(b);
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (est_fill < DEPTH) est_fill++;
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (est_fill > 0) est_fill--;
            end
            KIND_INSERT_AT: begin
                if (pos == 0) begin
                    if (est_fill < DEPTH) est_fill++;
                end else if (pos < est_fill && est_fill < DEPTH) begin
                    est_fill++;
                end
            end
            KIND_CLEAR: est_fill = 0;
            default: ;
        endcase
    endtask

    task automatic queue_random_op(input int mode);
        int r;
        int t_push, t_ins, t_read, t_pop, t_clr;
        int top;
        logic [KIND_W-1:0] k;
        logic [POS_W-1:0]  p;
        case (mode)
            MODE_GROW:   begin t_push = 45; t_ins = 75; t_read = 88; t_pop = 98; t_clr = 98; end
            MODE_SHRINK: begin t_push = 12; t_ins = 22; t_read = 35; t_pop = 97; t_clr = 98; end
            default:     begin t_push = 25; t_ins = 45; t_read = 68; t_pop = 95; t_clr = 97; end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_push)      k = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else if (r < t_ins)  k = KIND_INSERT_AT;
        else if (r < t_read) k = KIND_READ_AT;
        else if (r < t_pop)  k = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        else if (r < t_clr)  k = KIND_CLEAR;
        else                 k = KIND_UNUSED;

        // Mostly positions that hit a stored entry, some past the end,
        // some anywhere in the field.
        r = $urandom_range(0, 99);
        top = (est_fill > 256) ? 255 : est_fill - 1;
        if (r < 70 && est_fill > 0)        p = POS_W'($urandom_range(0, top));
        else if (r < 85 && est_fill < 256) p = POS_W'($urandom_range(est_fill, 255));
        else                               p = POS_W'($urandom_range(0, 255));
        queue_op(k, $urandom, p);
    endtask

    task automatic queue_random_phase(input int segments);
        int seg;
        int mode;
        for (seg = 0; seg < segments; seg++) begin
            mode = $urandom_range(MODE_GROW, MODE_MIX);
            repeat (50) queue_random_op(mode);
        end
    endtask

    // Returns once every queued beat has gone in and every result has come out.
    task automatic wait_drained();
        while (op_queue.size() != 0 || in_if.valid || deque_results_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Input driver: one beat from op_queue per handshake.
    always @(posedge i_clk) begin : drive_in
        t_op_beat b;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                deque_results_due.push_back(deque_apply(in_if.kind, in_if.value,
                                                        in_if.position));
            end
            if (!in_if.valid || in_if.ready) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    b = op_queue.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.kind     <= b.kind;
                    in_if.value    <= b.value;
                    in_if.position <= b.position;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin : check_out
        t_deque_result due;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (deque_results_due.size() == 0) begin
                    $display("%0t: unexpected beat: read_value %h status %0d count %0d",
                             $time, out_if.read_value, out_if.status, out_if.count_after);
                    mismatches++;
                end else begin
                    due = deque_results_due.pop_front();
                    if (out_if.read_value !== due.read_value) begin
                        $display("%0t: read_value expected %h, actual %h",
                                 $time, due.read_value, out_if.read_value);
                        mismatches++;
                    end
                    if (out_if.status !== due.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, due.status, out_if.status);
                        mismatches++;
                    end
                    if (out_if.count_after !== due.count_after) begin
                        $display("%0t: count_after expected %0d, actual %0d",
                                 $time, due.count_after, out_if.count_after);
                        mismatches++;
                    end
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin : rx_hold_timer
        wait (rx_hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_CLEAR;
        in_if.value     = '0;
        in_if.position  = '0;
        out_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty queue corner cases, then a small queue worked from both ends.
        queue_op(KIND_POP_FRONT,  32'h1111_1111, 8'd0);
        queue_op(KIND_POP_BACK,   32'h2222_2222, 8'd0);
        queue_op(KIND_READ_AT,    32'h0, 8'd0);
        queue_op(KIND_INSERT_AT,  32'h3333_3333, 8'd5);
        queue_op(KIND_INSERT_AT,  32'hFFFF_FFFF, 8'd0);
        queue_op(KIND_PUSH_BACK,  32'h0000_0000, 8'd255);
        queue_op(KIND_PUSH_FRONT, 32'hA5A5_5A5A, 8'd0);
        queue_op(KIND_PUSH_BACK,  32'h8000_0001, 8'd0);
        queue_op(KIND_READ_AT,    32'h0, 8'd0);
        queue_op(KIND_READ_AT,    32'h0, 8'd3);
        queue_op(KIND_READ_AT,    32'h0, 8'd4);
        queue_op(KIND_READ_AT,    32'h0, 8'd255);
        queue_op(KIND_INSERT_AT,  32'h1234_5678, 8'd2);
        queue_op(KIND_INSERT_AT,  32'h4444_4444, 8'd5);
        queue_op(KIND_INSERT_AT,  32'h5A5A_A5A5, 8'd4);
        queue_op(KIND_READ_AT,    32'h0, 8'd2);
        queue_op(KIND_UNUSED,     32'hDEAD_BEEF, 8'd1);
        queue_op(KIND_POP_FRONT,  32'h0, 8'd0);
        queue_op(KIND_POP_BACK,   32'h0, 8'd0);
        queue_op(KIND_CLEAR,      32'h0, 8'd0);
        queue_op(KIND_CLEAR,      32'h0, 8'd0);
        queue_op(KIND_POP_BACK,   32'h0, 8'd0);
        queue_op(KIND_PUSH_FRONT, 32'h0000_0007, 8'd0);
        queue_op(KIND_PUSH_BACK,  32'h7FFF_FFFE, 8'd0);
        queue_op(KIND_READ_AT,    32'h0, 8'd1);
        wait_drained();

        // No idling; fill to the bound under a long receiver hold-off,
        // probe the full queue, then shrink it.
        rx_hold_go = 1'b1;
        while (est_fill < DEPTH) queue_random_op(MODE_GROW);
        queue_op(KIND_PUSH_FRONT, $urandom, 8'd0);
        queue_op(KIND_PUSH_BACK,  $urandom, 8'd0);
        queue_op(KIND_INSERT_AT,  $urandom, 8'd0);
        queue_op(KIND_INSERT_AT,  $urandom, 8'd1);
        queue_op(KIND_INSERT_AT,  $urandom, 8'd255);
        queue_op(KIND_READ_AT,    32'h0, 8'd255);
        queue_op(KIND_READ_AT,    32'h0, 8'd0);
        repeat (80) queue_random_op(MODE_SHRINK);
        wait_drained();

        tx_idle_pct = 68;
        queue_random_phase(7);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 68;
        queue_random_phase(7);
        wait_drained();

        tx_idle_pct  = 31;
        rx_stall_pct = 31;
        queue_random_phase(7);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && deque_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
